>>> sv/free_flight_distance_sampler_macros.svh
// Assertion macros shared by the checker of the free-flight distance sampler.
`ifndef FREE_FLIGHT_DISTANCE_SAMPLER_MACROS_SVH
`define FREE_FLIGHT_DISTANCE_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FFD_ASSERT_NOW(label, clk, dis, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define FFD_ASSERT_NEXT(label, clk, dis, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/ffd_pkg.sv
// Shared types, constants and constant tables of the free-flight distance sampler.
package ffd_pkg;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SIGMA_RED   = 2'd0;
  localparam logic [1:0] REG_SIGMA_GREEN = 2'd1;
  localparam logic [1:0] REG_SIGMA_BLUE  = 2'd2;

  // Colour channel codes; the unused code behaves as red.
  localparam logic [1:0] CH_RED    = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_BLUE   = 2'd2;
  localparam logic [1:0] CH_UNUSED = 2'd3;

  localparam logic [23:0] SIGMA_RESET = 24'd65536;
  localparam logic [23:0] HALF_Q24    = 24'h800000;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;
  // Reciprocal of three scaled by 2^27, used for the mean over channels.
  localparam logic [25:0] RECIP3_Q27  = 26'd44739243;

  localparam int EXP_STEPS = 16;

  // Result of the front end, carried through the queue.
  typedef struct packed {
    logic [31:0] travel;
    logic        sat;
  } mid_t;

  // Factors 2^(-2^-k) in Q0.30 for k = 1 .. EXP_STEPS.
  typedef logic [EXP_STEPS:1][29:0] exp_tab_t;

  // Floor of the square root, worked out bit by bit.
  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] cand;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = r | (32'd1 << i);
      if ((64'(cand) * 64'(cand)) <= v) r = cand;
    end
    return r;
  endfunction

  // Each factor is the square root of the one before, starting at one half.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] prev;
    prev = 64'(ONE_Q30 >> 1);
    for (int k = 1; k <= EXP_STEPS; k++) begin
      tab[k] = 30'(isqrt64(prev << 30));
      prev   = 64'(tab[k]);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> sv/ffd_if.sv
// Request channel interfaces for samples in and results out.
interface ffd_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] uniform_sample;
  logic [1:0]  channel_pick;

  modport source (output valid, output uniform_sample, output channel_pick, input ready);
  modport sink (input valid, input uniform_sample, input channel_pick, output ready);
  modport monitor (input valid, input ready, input uniform_sample, input channel_pick);
endinterface

interface ffd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [16:0] trans_red;
  logic [16:0] trans_green;
  logic [16:0] trans_blue;
  logic [23:0] pdf_value;
  logic        saturated;

  modport source (output valid, output distance, output trans_red, output trans_green,
                  output trans_blue, output pdf_value, output saturated, input ready);
  modport sink (input valid, input distance, input trans_red, input trans_green,
                input trans_blue, input pdf_value, input saturated, output ready);
  modport monitor (input valid, input ready, input distance, input trans_red,
                   input trans_green, input trans_blue, input pdf_value, input saturated);
endinterface

>>> sv/ffd_front.sv
// Front end: picks the coefficient, takes the logarithm and divides to get the distance.
module ffd_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [23:0]  uniform_sample,
  input  logic [1:0]   channel_pick,
  input  logic [23:0]  sigma_red,
  input  logic [23:0]  sigma_green,
  input  logic [23:0]  sigma_blue,
  output logic         push,
  input  logic         full,
  output ffd_pkg::mid_t push_data
);

  localparam int SQ_N = 32;
  localparam int DV_N = 37;
  localparam int NF   = SQ_N + DV_N + 2;

  logic          ce;
  logic [NF-1:0] fv;

  logic [23:0] u_fix;
  logic [23:0] x;
  logic [4:0]  p0;
  logic [53:0] m_wide;
  logic [23:0] sg0;

  logic [30:0] sq_m  [0:SQ_N];
  logic [31:0] sq_fr [0:SQ_N];
  logic [4:0]  sq_p  [0:SQ_N];
  logic [23:0] sq_s  [0:SQ_N];
  logic [61:0] sq_prod     [1:SQ_N];
  logic [30:0] sq_m_next   [1:SQ_N];
  logic [31:0] sq_fr_next  [1:SQ_N];

  logic [36:0] l2;
  logic [63:0] lo_prod;
  logic [36:0] ln_val;

  logic [23:0] dv_rem [0:DV_N];
  logic [36:0] dv_num [0:DV_N];
  logic [36:0] dv_quo [0:DV_N];
  logic [23:0] dv_s   [0:DV_N];
  logic [24:0] dv_trial    [1:DV_N];
  logic [24:0] dv_diff     [1:DV_N];
  logic        dv_ge       [1:DV_N];
  logic [23:0] dv_rem_next [1:DV_N];

  logic last_sat;

  // The whole pipe moves whenever its last stage is empty or the queue has room.
  assign ce       = !fv[NF-1] || !full;
  assign in_ready = ce;
  assign push     = fv[NF-1] && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (ce) begin
      fv <= {fv[NF-2:0], in_valid};
    end
  end

  // Zero sample handling, complement and normalisation into Q1.30.
  always_comb begin
    u_fix = (uniform_sample == '0) ? ffd_pkg::HALF_Q24 : uniform_sample;
    x     = 24'(25'h1000000 - {1'b0, u_fix});
    p0    = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) p0 = 5'(i);
    end
    m_wide = {30'd0, x} << (5'd30 - p0);
  end

  // Coefficient of the chosen channel.
  always_comb begin
    unique case (channel_pick)
      ffd_pkg::CH_RED:    sg0 = sigma_red;
      ffd_pkg::CH_GREEN:  sg0 = sigma_green;
      ffd_pkg::CH_BLUE:   sg0 = sigma_blue;
      ffd_pkg::CH_UNUSED: sg0 = sigma_red;
      default:            sg0 = sigma_red;
    endcase
  end

  // One squaring per stage yields one fraction bit of the base-two logarithm.
  always_comb begin
    for (int k = 1; k <= SQ_N; k++) begin
      sq_prod[k] = 62'(sq_m[k-1]) * 62'(sq_m[k-1]);
      if (sq_prod[k][61]) begin
        sq_m_next[k]  = sq_prod[k][61:31];
        sq_fr_next[k] = sq_fr[k-1] | (32'd1 << (32 - k));
      end else begin
        sq_m_next[k]  = sq_prod[k][60:30];
        sq_fr_next[k] = sq_fr[k-1];
      end
    end
  end

  // Natural logarithm from the base-two one.
  always_comb begin
    l2      = {5'd24 - sq_p[SQ_N], 32'd0} - {5'd0, sq_fr[SQ_N]};
    lo_prod = 64'(l2[31:0]) * 64'(ffd_pkg::LN2_Q32);
    ln_val  = (37'(l2[36:32]) * 37'(ffd_pkg::LN2_Q32)) + 37'(lo_prod[63:32]);
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    for (int k = 1; k <= DV_N; k++) begin
      dv_trial[k] = {dv_rem[k-1], dv_num[k-1][36]};
      dv_diff[k]  = dv_trial[k] - {1'b0, dv_s[k-1]};
      dv_ge[k]    = dv_trial[k] >= {1'b0, dv_s[k-1]};
      dv_rem_next[k] = dv_ge[k] ? dv_diff[k][23:0] : dv_trial[k][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_m[0]  <= m_wide[30:0];
      sq_fr[0] <= '0;
      sq_p[0]  <= p0;
      sq_s[0]  <= sg0;
      for (int k = 1; k <= SQ_N; k++) begin
        sq_m[k]  <= sq_m_next[k];
        sq_fr[k] <= sq_fr_next[k];
        sq_p[k]  <= sq_p[k-1];
        sq_s[k]  <= sq_s[k-1];
      end
      dv_rem[0] <= '0;
      dv_num[0] <= ln_val;
      dv_quo[0] <= '0;
      dv_s[0]   <= sq_s[SQ_N];
      for (int k = 1; k <= DV_N; k++) begin
        dv_rem[k] <= dv_rem_next[k];
        dv_num[k] <= {dv_num[k-1][35:0], 1'b0};
        dv_quo[k] <= {dv_quo[k-1][35:0], dv_ge[k]};
        dv_s[k]   <= dv_s[k-1];
      end
    end
  end

  // Saturate on a zero coefficient or a quotient beyond 32 bits.
  assign last_sat         = (dv_s[DV_N] == '0) || (dv_quo[DV_N][36:32] != '0);
  assign push_data.sat    = last_sat;
  assign push_data.travel = last_sat ? 32'hFFFFFFFF : dv_quo[DV_N][31:0];

endmodule

>>> sv/ffd_queue.sv
// Short queue between the front and back ends.
module ffd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ffd_pkg::mid_t push_data,
  output logic          full,
  input  logic          pop,
  output ffd_pkg::mid_t head,
  output logic          not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ffd_pkg::mid_t    slots [0:DEPTH-1];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  // Pointers wrap at the depth; the count follows pushes and pops.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

>>> sv/ffd_back.sv
// Back end: transmittance of each channel and the mean pdf for a given distance.
module ffd_back (
  input  logic          clk,
  input  logic          rst,
  input  ffd_pkg::mid_t head,
  input  logic          not_empty,
  output logic          pop,
  input  logic [23:0]   sigma_red,
  input  logic [23:0]   sigma_green,
  input  logic [23:0]   sigma_blue,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   distance,
  output logic [16:0]   trans_red,
  output logic [16:0]   trans_green,
  output logic [16:0]   trans_blue,
  output logic [23:0]   pdf_value,
  output logic          saturated
);

  localparam int NS = ffd_pkg::EXP_STEPS;
  localparam int ST_T = NS + 2;
  localparam int NB = ST_T + 4;

  logic          ce;
  logic [NB-1:0] bv;
  logic [23:0]   sg [0:2];

  logic [31:0] bd   [0:NB-1];
  logic        bsat [0:NB-1];

  logic [55:0] e_prod [0:2];
  logic [55:0] e_reg  [0:2];

  logic [35:0] y_hi   [0:2];
  logic [62:0] y_lo   [0:2];
  logic [37:0] y_val  [0:2];

  logic [30:0] r    [0:NS][0:2];
  logic [5:0]  en   [0:NS][0:2];
  logic [15:0] fb   [0:NS][0:2];
  logic        ez   [0:NS][0:2];
  logic [60:0] r_prod [1:NS][0:2];
  logic [30:0] r_next [1:NS][0:2];

  logic [6:0]  sh     [0:2];
  logic [39:0] t_wide [0:2];
  logic [16:0] t_next [0:2];
  logic [16:0] tr     [0:3][0:2];

  logic [40:0] pr [0:2];
  logic [42:0] p_sum;
  logic [25:0] mean_in;
  logic [51:0] mean_prod;
  logic [23:0] pdf_reg;

  assign sg[0] = sigma_red;
  assign sg[1] = sigma_green;
  assign sg[2] = sigma_blue;

  // The pipe moves when the result register is free or being taken.
  assign ce  = !bv[NB-1] || out_ready;
  assign pop = ce && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (ce) begin
      bv <= {bv[NB-2:0], not_empty};
    end
  end

  // Exponent per channel, then its base-two form.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_prod[c] = 56'(sg[c]) * 56'(head.travel);
      y_hi[c]   = 36'(e_reg[c][36:32]) * 36'(ffd_pkg::LOG2E_Q30);
      y_lo[c]   = 63'(e_reg[c][31:0]) * 63'(ffd_pkg::LOG2E_Q30);
      y_val[c]  = {y_hi[c], 2'b00} + 38'(y_lo[c][62:30]);
    end
  end

  // One factor of the fractional power per stage.
  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      for (int c = 0; c < 3; c++) begin
        r_prod[k][c] = 61'(r[k-1][c]) * 61'(ffd_pkg::EXP_TAB[k]);
        r_next[k][c] = fb[k-1][c][NS-k] ? r_prod[k][c][60:30] : r[k-1][c];
      end
    end
  end

  // Integer part of the power as a rounded right shift.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c]     = 7'(en[NS][c]) + 7'd14;
      t_wide[c] = (40'(r[NS][c]) + (40'd1 << (sh[c] - 7'd1))) >> sh[c];
      t_next[c] = (ez[NS][c] || (sh[c] >= 7'd40)) ? '0 : t_wide[c][16:0];
    end
  end

  // Mean of the three weighted transmittances, divided by three through a reciprocal.
  always_comb begin
    p_sum     = 43'(pr[0]) + 43'(pr[1]) + 43'(pr[2]);
    mean_prod = 52'(mean_in) * 52'(ffd_pkg::RECIP3_Q27);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bd[0]   <= head.travel;
      bsat[0] <= head.sat;
      for (int s = 1; s < NB; s++) begin
        bd[s]   <= bd[s-1];
        bsat[s] <= bsat[s-1];
      end
      for (int c = 0; c < 3; c++) begin
        e_reg[c] <= e_prod[c];
        r[0][c]  <= ffd_pkg::ONE_Q30;
        en[0][c] <= y_val[c][37:32];
        fb[0][c] <= y_val[c][31:16];
        ez[0][c] <= (e_reg[c][55:37] != '0);
        for (int k = 1; k <= NS; k++) begin
          r[k][c]  <= r_next[k][c];
          en[k][c] <= en[k-1][c];
          fb[k][c] <= fb[k-1][c];
          ez[k][c] <= ez[k-1][c];
        end
        tr[0][c] <= t_next[c];
        for (int s = 1; s < 4; s++) begin
          tr[s][c] <= tr[s-1][c];
        end
        pr[c] <= 41'(sg[c]) * 41'(tr[0][c]);
      end
      mean_in <= p_sum[41:16];
      pdf_reg <= mean_prod[50:27];
    end
  end

  assign out_valid   = bv[NB-1];
  assign distance    = bd[NB-1];
  assign saturated   = bsat[NB-1];
  assign trans_red   = tr[3][0];
  assign trans_green = tr[3][1];
  assign trans_blue  = tr[3][2];
  assign pdf_value   = pdf_reg;

endmodule

>>> sv/free_flight_distance_sampler.sv
// Top level of the free-flight distance sampler with its register port.
//
// The sampler takes one request per clock cycle unless a full queue holds the
// front end, and returns one result per request, in order. A request passes
// 71 front-end stages (normalisation, 32 squaring stages for the logarithm,
// the logarithm scale and a 37-stage restoring divider), a queue of
// QUEUE_DEPTH entries, and 22 back-end stages (exponent multiply, base-two
// conversion, 16 factor stages, round and shift, and three stages for the
// pdf). The coefficients sigma_red, sigma_green and sigma_blue sit at byte
// addresses 0, 4 and 8; they are read by requests in flight and are only to
// be changed while the block is empty.
module free_flight_distance_sampler #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  ffd_in_if.sink       sample,
  ffd_out_if.source    result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [23:0]   sigma_red;
  logic [23:0]   sigma_green;
  logic [23:0]   sigma_blue;
  logic          wr_en;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  ffd_pkg::mid_t q_in;
  ffd_pkg::mid_t q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes; only the low 24 bits are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_red   <= ffd_pkg::SIGMA_RESET;
      sigma_green <= ffd_pkg::SIGMA_RESET;
      sigma_blue  <= ffd_pkg::SIGMA_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        ffd_pkg::REG_SIGMA_RED:   sigma_red   <= pwdata[23:0];
        ffd_pkg::REG_SIGMA_GREEN: sigma_green <= pwdata[23:0];
        ffd_pkg::REG_SIGMA_BLUE:  sigma_blue  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      ffd_pkg::REG_SIGMA_RED:   prdata = {8'd0, sigma_red};
      ffd_pkg::REG_SIGMA_GREEN: prdata = {8'd0, sigma_green};
      ffd_pkg::REG_SIGMA_BLUE:  prdata = {8'd0, sigma_blue};
      default:                  prdata = '0;
    endcase
  end

  ffd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (sample.valid),
    .in_ready       (sample.ready),
    .uniform_sample (sample.uniform_sample),
    .channel_pick   (sample.channel_pick),
    .sigma_red      (sigma_red),
    .sigma_green    (sigma_green),
    .sigma_blue     (sigma_blue),
    .push           (q_push),
    .full           (q_full),
    .push_data      (q_in)
  );

  ffd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  ffd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .not_empty   (q_not_empty),
    .pop         (q_pop),
    .sigma_red   (sigma_red),
    .sigma_green (sigma_green),
    .sigma_blue  (sigma_blue),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .distance    (result.distance),
    .trans_red   (result.trans_red),
    .trans_green (result.trans_green),
    .trans_blue  (result.trans_blue),
    .pdf_value   (result.pdf_value),
    .saturated   (result.saturated)
  );

endmodule

>>> sv/ffd_checker.sv
// Port-level checker of the free-flight distance sampler and its bind.
`include "free_flight_distance_sampler_macros.svh"

module ffd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [31:0] distance,
  input logic [16:0] trans_red,
  input logic [16:0] trans_green,
  input logic [16:0] trans_blue,
  input logic [23:0] pdf_value,
  input logic        saturated
);

  logic trans_le_one;
  logic trans_all_zero;

  // Range and zero tests over the three transmittances.
  assign trans_le_one   = (trans_red <= 17'd65536) && (trans_green <= 17'd65536) &&
                          (trans_blue <= 17'd65536);
  assign trans_all_zero = (trans_red == '0) && (trans_green == '0) && (trans_blue == '0);

  // No result is shown right after reset.
  `FFD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !valid, "result valid after reset")

  // A waiting result stays offered.
  `FFD_ASSERT_NEXT(a_result_held, clk, rst, valid && !ready, valid, "result dropped")

  // A saturated result carries the largest distance.
  `FFD_ASSERT_NOW(a_sat_dist, clk, rst, valid && saturated, distance == 32'hFFFFFFFF, "bad sat")

  // Transmittance never exceeds one, and zero transmittance gives a zero pdf.
  `FFD_ASSERT_NOW(a_trans_range, clk, rst, valid, trans_le_one, "transmittance above one")
  `FFD_ASSERT_NOW(a_pdf_zero, clk, rst, valid && trans_all_zero, pdf_value == '0, "pdf not zero")

endmodule

bind free_flight_distance_sampler ffd_checker u_ffd_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .distance    (result.distance),
  .trans_red   (result.trans_red),
  .trans_green (result.trans_green),
  .trans_blue  (result.trans_blue),
  .pdf_value   (result.pdf_value),
  .saturated   (result.saturated)
);

>>> sim/free_flight_distance_sampler_checker.sv
// Checker that predicts and compares every result of the free-flight distance sampler.
module free_flight_distance_sampler_checker (
  input  logic            clk,
  input  logic            rst,
  ffd_in_if.monitor       sample,
  ffd_out_if.monitor      result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output int              fail_count,
  output int              pending,
  output int              checked,
  output int              sat_seen
);

  typedef struct packed {
    logic [31:0] travel;
    logic [16:0] tr;
    logic [16:0] tg;
    logic [16:0] tb;
    logic [23:0] pdf;
    logic        sat;
  } flight_t;

  localparam logic [63:0] LN2_SCALE   = 64'd2977044472;
  localparam logic [63:0] LOG2E_SCALE = 64'd1549082005;
  localparam logic [63:0] UNIT_Q30    = 64'd1073741824;
  localparam logic [63:0] ALL_ONES32  = 64'hFFFF_FFFF;

  logic [23:0] sigma_r, sigma_g, sigma_b;
  logic [63:0] halving [0:16];
  flight_t     flight_q [$];

  // Floor of the square root, by the shift-and-subtract method.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Natural log of 2^24/x in Q.32 via repeated squaring.
  function automatic logic [63:0] neg_log(input logic [23:0] x);
    int          p;
    logic [63:0] m, frac, l2;
    p = 23;
    frac = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = 64'(x) << (30 - p);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (UNIT_Q30 << 1)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (31 - i));
      end
    end
    l2 = (64'(24 - p) << 32) - frac;
    return (l2 >> 32) * LN2_SCALE + (((l2 & ALL_ONES32) * LN2_SCALE) >> 32);
  endfunction

  // Attenuation exp(-e) for e in Q.32, returned in Q1.16.
  function automatic logic [16:0] attenuation(input logic [63:0] e);
    logic [63:0] y, f, r;
    int          shamt;
    if ((e >> 32) >= 32) return 17'd0;
    y = (((e >> 32) * LOG2E_SCALE) << 2) + (((e & ALL_ONES32) * LOG2E_SCALE) >> 30);
    f = y & ALL_ONES32;
    r = UNIT_Q30;
    for (int k = 1; k <= 16; k++)
      if (f[32 - k]) r = (r * halving[k]) >> 30;
    shamt = int'(y >> 32) + 14;
    if (shamt >= 40) return 17'd0;
    return 17'((r + (64'd1 << (shamt - 1))) >> shamt);
  endfunction

  function automatic flight_t predict_flight(input logic [23:0] u, input logic [1:0] ch);
    flight_t     res;
    logic [23:0] sig [0:2];
    logic [23:0] s;
    logic [63:0] ln_val, d, total;
    sig[0] = sigma_r;
    sig[1] = sigma_g;
    sig[2] = sigma_b;
    s = (ch == ffd_pkg::CH_UNUSED) ? sig[0] : sig[ch];
    if (u == 24'd0) u = ffd_pkg::HALF_Q24;
    ln_val = neg_log(24'(25'h1000000 - 25'(u)));
    res.sat = 1'b0;
    if (s == 0) begin
      d = ALL_ONES32;
      res.sat = 1'b1;
    end else begin
      d = ln_val / 64'(s);
      if (d > ALL_ONES32) begin
        d = ALL_ONES32;
        res.sat = 1'b1;
      end
    end
    res.travel = d[31:0];
    res.tr = attenuation(64'(sig[0]) * d);
    res.tg = attenuation(64'(sig[1]) * d);
    res.tb = attenuation(64'(sig[2]) * d);
    total = 64'(sig[0]) * res.tr + 64'(sig[1]) * res.tg + 64'(sig[2]) * res.tb;
    res.pdf = 24'(total / 64'd196608);
    return res;
  endfunction

  initial begin
    halving[0] = UNIT_Q30 >> 1;
    for (int k = 1; k <= 16; k++) halving[k] = root_floor(halving[k - 1] << 30);
    fail_count = 0;
    checked = 0;
    sat_seen = 0;
  end

  assign pending = flight_q.size();

  // Track register writes, predict on each accepted request, compare on each result.
  always @(posedge clk) begin
    flight_t want;
    flight_t got;
    if (rst) begin
      sigma_r <= ffd_pkg::SIGMA_RESET;
      sigma_g <= ffd_pkg::SIGMA_RESET;
      sigma_b <= ffd_pkg::SIGMA_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ffd_pkg::REG_SIGMA_RED:   sigma_r <= pwdata[23:0];
          ffd_pkg::REG_SIGMA_GREEN: sigma_g <= pwdata[23:0];
          ffd_pkg::REG_SIGMA_BLUE:  sigma_b <= pwdata[23:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        flight_q.push_back(predict_flight(sample.uniform_sample, sample.channel_pick));
      if (result.valid && result.ready) begin
        got = {result.distance, result.trans_red, result.trans_green, result.trans_blue,
               result.pdf_value, result.saturated};
        if (flight_q.size() == 0) begin
          $display("%0t: result with none expected: got %h", $time, got);
          fail_count++;
        end else begin
          want = flight_q.pop_front();
          checked++;
          if (want.sat) sat_seen++;
          if (got.travel !== want.travel) begin
            $display("%0t: distance expected %h actual %h", $time, want.travel, got.travel);
            fail_count++;
          end
          if (got.tr !== want.tr) begin
            $display("%0t: trans_red expected %h actual %h", $time, want.tr, got.tr);
            fail_count++;
          end
          if (got.tg !== want.tg) begin
            $display("%0t: trans_green expected %h actual %h", $time, want.tg, got.tg);
            fail_count++;
          end
          if (got.tb !== want.tb) begin
            $display("%0t: trans_blue expected %h actual %h", $time, want.tb, got.tb);
            fail_count++;
          end
          if (got.pdf !== want.pdf) begin
            $display("%0t: pdf_value expected %h actual %h", $time, want.pdf, got.pdf);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> sim/free_flight_distance_sampler_tb.sv
// Testbench top of the free-flight distance sampler: stimulus, register writes and verdict.
module free_flight_distance_sampler_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, checked, sat_seen;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          sent = 0;

  ffd_in_if  sample_ch ();
  ffd_out_if result_ch ();

  free_flight_distance_sampler u_top (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  free_flight_distance_sampler_checker u_checker (
    .clk(clk), .rst(rst), .sample(sample_ch.monitor), .result(result_ch.monitor),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
    .checked(checked), .sat_seen(sat_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.uniform_sample = '0;
    sample_ch.channel_pick = '0;
    result_ch.ready = 1'b0;
  end

  // The result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    result_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("free_flight_distance_sampler_tb failed");
      $finish;
    end
  end

  task automatic write_sigma(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Quiesce the pipeline, then load all three coefficients; upper bits are junk.
  task automatic load_sigmas(input logic [23:0] r, input logic [23:0] g,
                             input logic [23:0] b);
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_sigma(ffd_pkg::REG_SIGMA_RED, {8'($urandom_range(255)), r});
    write_sigma(ffd_pkg::REG_SIGMA_GREEN, {8'($urandom_range(255)), g});
    write_sigma(ffd_pkg::REG_SIGMA_BLUE, {8'($urandom_range(255)), b});
  endtask

  task automatic send_request(input logic [23:0] u, input logic [1:0] ch);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.uniform_sample <= u;
    sample_ch.channel_pick <= ch;
    do begin
      @(negedge clk);
      taken = sample_ch.ready;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  function automatic logic [23:0] rand_uniform();
    case ($urandom_range(5))
      0: return 24'($urandom_range(255));
      1: return 24'hFFFFFF - 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_sigma();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'($urandom_range(255));
      2: return 24'hFFFFFF - 24'($urandom_range(4095));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset coefficients, extremes of the sample, every channel code.
    send_request(24'd0, ffd_pkg::CH_RED);
    send_request(24'd1, ffd_pkg::CH_GREEN);
    send_request(24'hFFFFFF, ffd_pkg::CH_BLUE);
    send_request(24'h800000, ffd_pkg::CH_UNUSED);
    send_request(24'h555555, ffd_pkg::CH_RED);
    send_request(24'hAAAAAA, ffd_pkg::CH_GREEN);

    // Directed: zero, tiny and full-scale coefficients, with overflow of the distance.
    load_sigmas(24'd0, 24'd1, 24'hFFFFFF);
    send_request(24'h123456, ffd_pkg::CH_RED);
    send_request(24'hFFFFFF, ffd_pkg::CH_GREEN);
    send_request(24'd1, ffd_pkg::CH_GREEN);
    send_request(24'd0, ffd_pkg::CH_BLUE);
    send_request(24'hFFFFFF, ffd_pkg::CH_BLUE);
    send_request(24'h400000, ffd_pkg::CH_UNUSED);
    load_sigmas(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_request(24'd1, ffd_pkg::CH_RED);
    send_request(24'hFFFFFF, ffd_pkg::CH_UNUSED);
    send_request(24'd0, ffd_pkg::CH_GREEN);
    load_sigmas(24'd1, 24'd0, 24'd0);
    send_request(24'hFFFFFF, ffd_pkg::CH_RED);
    send_request(24'd1, ffd_pkg::CH_RED);
    send_request(24'h800000, ffd_pkg::CH_BLUE);

    // Random phases cycling through idle patterns and coefficient settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      if (phase == 0) begin
        load_sigmas(ffd_pkg::SIGMA_RESET, ffd_pkg::SIGMA_RESET, ffd_pkg::SIGMA_RESET);
      end else begin
        load_sigmas(rand_sigma(), rand_sigma(), rand_sigma());
      end
      for (int i = 0; i < 50; i++)
        send_request(rand_uniform(), 2'($urandom_range(3)));
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples over twelve coefficient settings; %0d results checked.",
             sent, checked);
    $display("%0d results had a saturated distance.", sat_seen);
    if (fail_count == 0) begin
      $display("free_flight_distance_sampler_tb passed");
    end else begin
      $display("free_flight_distance_sampler_tb failed");
    end
    $finish;
  end
endmodule
